>>> src/wald_pkg.sv
// Shared widths and constants for the wrapped-angle lag difference window sum.
// No dependencies; imported by every module of the block.
package wald_pkg;

  localparam int YAW_W       = 15;
  localparam int DIFF_W      = 16;
  localparam int OUT_W       = 20;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;
  localparam int LAG         = 3;

  // 80, 280 and 360 degrees with 6 fraction bits
  localparam logic [YAW_W-1:0]         LOW_EDGE  = 15'd5120;
  localparam logic [YAW_W-1:0]         HIGH_EDGE = 15'd17920;
  localparam logic signed [DIFF_W:0]   FULL_TURN = 17'sd23040;

  typedef logic [YAW_W-1:0]         yaw_t;
  typedef logic signed [DIFF_W-1:0] diff_t;

endpackage

>>> src/wald_unwrap.sv
// Lag-3 delay line of raw samples and the seam-unwrapped difference.
// Depends on wald_pkg.
module wald_unwrap (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  wald_pkg::yaw_t  sample,
  output wald_pkg::diff_t diff
);
  import wald_pkg::*;

  yaw_t                  lag_r [LAG];
  yaw_t                  old_smp;
  logic signed [DIFF_W:0] raw_diff;
  logic signed [DIFF_W:0] adj_diff;

  assign old_smp  = lag_r[LAG-1];
  assign raw_diff = $signed({2'b00, sample}) - $signed({2'b00, old_smp});

  always_comb begin
    if ((sample < LOW_EDGE) && (old_smp > HIGH_EDGE)) begin
      adj_diff = raw_diff + FULL_TURN;
    end else if ((sample > HIGH_EDGE) && (old_smp < LOW_EDGE)) begin
      adj_diff = raw_diff - FULL_TURN;
    end else begin
      adj_diff = raw_diff;
    end
  end

  assign diff = adj_diff[DIFF_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAG; i++) lag_r[i] <= '0;
    end else if (adv) begin
      lag_r[0] <= sample;
      for (int i = 1; i < LAG; i++) lag_r[i] <= lag_r[i-1];
    end
  end

  // samples no more than 80 degrees apart are never unwrapped
  a_no_wrap_when_close: assert property (@(posedge clk) disable iff (!rst_n)
    (sample <= old_smp + YAW_W'(LOW_EDGE) && old_smp <= sample + YAW_W'(LOW_EDGE))
      |-> (adj_diff == raw_diff))
    else $error("unwrap applied to close samples");

endmodule

>>> src/wald_window.sv
// Window of stored differences as a shift line, exact running sum and output clamp.
// Depends on wald_pkg.
module wald_window #(
  parameter int WINDOW = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  wald_pkg::diff_t              diff,
  output logic [wald_pkg::OUT_W-1:0]   sum_sat
);
  import wald_pkg::*;

  localparam int SUM_W = DIFF_W + $clog2(WINDOW);
  localparam int CMP_W = (SUM_W > OUT_W) ? SUM_W : OUT_W;

  localparam logic signed [CMP_W-1:0] SAT_MAX =
    {{(CMP_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [CMP_W-1:0] SAT_MIN =
    {{(CMP_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

  diff_t                   line_r [WINDOW];
  logic signed [SUM_W-1:0] sum_r;
  logic signed [SUM_W-1:0] sum_nxt;
  logic signed [CMP_W-1:0] sum_ext;

  assign sum_nxt = sum_r + SUM_W'(diff) - SUM_W'(line_r[WINDOW-1]);
  assign sum_ext = CMP_W'(sum_nxt);

  always_comb begin
    if (sum_ext > SAT_MAX) begin
      sum_sat = SAT_MAX[OUT_W-1:0];
    end else if (sum_ext < SAT_MIN) begin
      sum_sat = SAT_MIN[OUT_W-1:0];
    end else begin
      sum_sat = sum_ext[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW; i++) line_r[i] <= '0;
      sum_r <= '0;
    end else if (adv) begin
      line_r[0] <= diff;
      for (int i = 1; i < WINDOW; i++) line_r[i] <= line_r[i-1];
      sum_r <= sum_nxt;
    end
  end

  a_sum_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(sum_r))
    else $error("running sum moved without a transaction");

  a_line_shift: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> (line_r[0] == $past(diff)))
    else $error("difference not stored at head of window");

endmodule

>>> src/wrapped_angle_lag_diff_window_sum_core.sv
// Top level: stream ports, input register, handshake control and result register.
// Depends on wald_pkg, wald_unwrap and wald_window.
//
//  channel | dir | tdata fields (low bit up)      | width
//  in_     | in  | yaw_sample[14:0], pad[15]      | 16
//  out_    | out | diff_sum[19:0] signed, pad     | 24
//
// One transaction per cycle sustained while results are taken; the path from input to result is
// the input register, then the unwrap/sum logic into the result register.
// Synchronous active-low reset clears the lag line, window line, sum and valids.
// A stalled result holds; the input register keeps taking data while it is empty
// or the result register is free or being taken in the same cycle.
module wrapped_angle_lag_diff_window_sum_core #(
  parameter int WINDOW = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [wald_pkg::IN_TDATA_W-1:0]    in_tdata,   // [14:0] yaw_sample
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [wald_pkg::OUT_TDATA_W-1:0]   out_tdata   // [19:0] diff_sum
);
  import wald_pkg::*;

  logic             s1_valid_r;
  yaw_t             s1_sample_r;
  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r;
  logic             out_free;
  logic             adv;
  diff_t            diff;
  logic [OUT_W-1:0] sum_sat;

  assign out_free  = !out_valid_r || out_tready;
  assign adv       = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) s1_valid_r <= in_tvalid;
      if (out_free)  out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) s1_sample_r <= in_tdata[YAW_W-1:0];
    if (adv)                    out_data_r  <= sum_sat;
  end

  wald_unwrap u_unwrap (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .sample (s1_sample_r),
    .diff   (diff)
  );

  wald_window #(
    .WINDOW (WINDOW)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .diff    (diff),
    .sum_sat (sum_sat)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-OUT_W){1'b0}}, out_data_r};

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_tvalid)
    else $error("input stage advanced without producing a result");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while result side drains");

endmodule
